/* rtl/uvs_pkg.sv */
package uvs_pkg;

  localparam int STACK_MAX = 256;
  localparam int SLICE_MAX = 256;
  localparam int CNT_W = 9;
  localparam int IDX_W = 8;

  localparam logic CFG_STACK = 1'b0;
  localparam logic CFG_SLICE = 1'b1;

  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_LAST = 3'd5;

  localparam int DIV_STAGES = 7;
  localparam int DIV_STEP = 3;
  localparam int SC_STAGES = 10;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  localparam logic [63:0] RCP_42 = ((64'd1 << 36) + 64'd41) / 64'd42;
  localparam logic [63:0] RCP_56 = ((64'd1 << 36) + 64'd55) / 64'd56;
  localparam logic [63:0] RCP_20 = ((64'd1 << 35) + 64'd19) / 64'd20;
  localparam logic [63:0] RCP_30 = ((64'd1 << 35) + 64'd29) / 64'd30;
  localparam logic [63:0] RCP_6 = ((64'd1 << 33) + 64'd5) / 64'd6;
  localparam logic [63:0] RCP_12 = ((64'd1 << 34) + 64'd11) / 64'd12;

  typedef struct packed {
    logic [9:0]  rem;
    logic [20:0] low;
    logic [20:0] quo;
  } div_st_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swp;
  } sc_meta_t;

  function automatic div_st_t div_step(div_st_t st, logic [9:0] den);
    logic [10:0] t;
    div_st_t s;
    s = st;
    for (int b = 0; b < DIV_STEP; b++) begin
      t = {s.rem, s.low[20]};
      s.low = {s.low[19:0], 1'b0};
      if (t >= {1'b0, den}) begin
        s.rem = 10'(t - {1'b0, den});
        s.quo = {s.quo[19:0], 1'b1};
      end else begin
        s.rem = t[9:0];
        s.quo = {s.quo[19:0], 1'b0};
      end
    end
    return s;
  endfunction

  // floor(n / d) through a rounded-up reciprocal, exact for n below 2^30
  function automatic logic [29:0] cdiv(logic [29:0] n, logic [63:0] rcp, int sh);
    logic [60:0] p;
    p = n * rcp[30:0];
    return 30'(p >> sh);
  endfunction

  function automatic logic [29:0] mulq(logic [29:0] a, logic [30:0] b);
    logic [60:0] p;
    p = a * b;
    return 30'(p >> 30);
  endfunction

  function automatic logic [15:0] rnd16(logic signed [62:0] v, int sh);
    logic [62:0] mag;
    logic [62:0] r;
    mag = v[62] ? 63'(-v) : 63'(v);
    r = (mag + (63'd1 << (sh - 1))) >> sh;
    return v[62] ? (16'd0 - r[15:0]) : r[15:0];
  endfunction

endpackage

/* rtl/uvs_div.sv */
module uvs_div
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [28:0] dividend,
  input  logic [9:0]  divisor,
  output logic [20:0] quotient
);

  div_st_t    st  [DIV_STAGES];
  logic [9:0] den [DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(div_st_t'{rem: {2'b00, dividend[28:21]}, low: dividend[20:0],
                                  quo: 21'd0}, divisor);
      den[0] <= divisor;
      for (int n = 1; n < DIV_STAGES; n++) begin
        st[n] <= div_step(st[n-1], den[n-1]);
      end
      for (int n = 1; n < DIV_STAGES - 1; n++) begin
        den[n] <= den[n-1];
      end
    end
  end

  assign quotient = st[DIV_STAGES-1].quo;

endmodule

/* rtl/uvs_sincos.sv */
module uvs_sincos
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [19:0]        phase,
  output logic signed [31:0] sin_q30,
  output logic signed [31:0] cos_q30
);

  logic [17:0] r_in;
  logic        swp_in;
  logic [17:0] a1;
  logic [48:0] xp;
  logic [59:0] xx;
  sc_meta_t    meta [1:9];
  logic [29:0] xs   [2:8];
  logic [29:0] sqs  [3:8];
  logic [29:0] sn4, cs4, sn5, cs5, sn6, cs6, sn7, cs7, sn8, cs8;
  logic [29:0] sn9;
  logic [30:0] cs9;
  logic [30:0] s0, c0;

  assign r_in = phase[17:0];
  assign swp_in = r_in > 18'h20000;
  assign xp = a1 * TWO_PI_Q28 + 49'h20000;
  assign xx = xs[2] * xs[2];
  assign s0 = meta[9].swp ? cs9 : {1'b0, sn9};
  assign c0 = meta[9].swp ? {1'b0, sn9} : cs9;

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= swp_in ? 18'(19'h40000 - {1'b0, r_in}) : r_in;
      meta[1] <= sc_meta_t'{quad: phase[19:18], swp: swp_in};
      for (int n = 2; n <= 9; n++) begin
        meta[n] <= meta[n-1];
      end
      xs[2] <= 30'(xp >> 18);
      for (int n = 3; n <= 8; n++) begin
        xs[n] <= xs[n-1];
      end
      sqs[3] <= 30'(xx >> 30);
      for (int n = 4; n <= 8; n++) begin
        sqs[n] <= sqs[n-1];
      end
      sn4 <= cdiv(sqs[3], RCP_42, 36);
      cs4 <= cdiv(sqs[3], RCP_56, 36);
      sn5 <= mulq(sqs[4], ONE_Q30 - {1'b0, sn4});
      cs5 <= mulq(sqs[4], ONE_Q30 - {1'b0, cs4});
      sn6 <= cdiv(sn5, RCP_20, 35);
      cs6 <= cdiv(cs5, RCP_30, 35);
      sn7 <= mulq(sqs[6], ONE_Q30 - {1'b0, sn6});
      cs7 <= mulq(sqs[6], ONE_Q30 - {1'b0, cs6});
      sn8 <= cdiv(sn7, RCP_6, 33);
      cs8 <= cdiv(cs7, RCP_12, 34);
      sn9 <= mulq(xs[8], ONE_Q30 - {1'b0, sn8});
      cs9 <= ONE_Q30 - {1'b0, mulq(sqs[8], ONE_Q30 - {1'b0, cs8}) >> 1};
      unique case (meta[9].quad)
        2'd0: begin
          sin_q30 <= $signed({1'b0, s0});
          cos_q30 <= $signed({1'b0, c0});
        end
        2'd1: begin
          sin_q30 <= $signed({1'b0, c0});
          cos_q30 <= -$signed({1'b0, s0});
        end
        2'd2: begin
          sin_q30 <= -$signed({1'b0, s0});
          cos_q30 <= -$signed({1'b0, c0});
        end
        default: begin
          sin_q30 <= -$signed({1'b0, c0});
          cos_q30 <= $signed({1'b0, s0});
        end
      endcase
    end
  end

endmodule

/* rtl/uv_sphere_cell_vertex_generator.sv */
// channel   direction  handshake              contents
// s_axis    in         s_tvalid / s_tready    one grid cell (stack, slice)
// m_axis    out        m_tvalid / m_tready    one vertex, m_tlast on the sixth
// cfg       in         cfg_valid / cfg_ready  register index and 9-bit value
//
// One vertex leaves per cycle while the output is not stalled; a new cell is taken
// as the six-step vertex sequencer issues the last vertex of the cell before it. The
// path to the output runs through 7 divider stages, 10 sine/cosine stages, product, output.
// A cell outside the current grid is taken and yields nothing.
// Reset is synchronous; it clears valid bits and the sequencer and sets both counts to 16.
// A stalled output word freezes every stage through one enable.
module uv_sphere_cell_vertex_generator
  import uvs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,    // stack_index, slice_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,    // pos_x/y/z, nrm_x/y/z, tan_x/y/z, tex_u, tex_v, zeros
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int SIDE_LEN = DIV_STAGES + SC_STAGES + 1;
  localparam int TEX_LEN = SC_STAGES + 1;

  logic [CNT_W-1:0] stack_count, slice_count;
  logic [CNT_W-1:0] ns, nl;
  logic             en;
  logic             busy;
  logic [2:0]       cnt;
  logic [IDX_W-1:0] ci, cj;
  logic             s_fire, in_range;
  logic             sel_up, sel_hi;
  logic [8:0]       vk, vm;
  logic             jv, jpole, jlast;
  logic [8:0]       jk, jm;
  logic [20:0]      th_quo, ph_quo, u_quo, v_quo;
  logic signed [31:0] ts, tc, ps, pc;
  logic             vp    [SIDE_LEN];
  logic             pole_d[SIDE_LEN];
  logic             last_d[SIDE_LEN];
  logic [14:0]      u_d   [TEX_LEN];
  logic [14:0]      v_d   [TEX_LEN];
  logic signed [62:0] pr_sc, pr_ss, pr_cc, pr_cs, tc_w, nts_w;
  logic [15:0]      pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z;
  logic [14:0]      tex_u, tex_v;

  assign ns = (stack_count == '0) ? CNT_W'(1) :
              (stack_count > CNT_W'(STACK_MAX)) ? CNT_W'(STACK_MAX) : stack_count;
  assign nl = (slice_count == '0) ? CNT_W'(1) :
              (slice_count > CNT_W'(SLICE_MAX)) ? CNT_W'(SLICE_MAX) : slice_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= CNT_W'(16);
      slice_count <= CNT_W'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STACK: stack_count <= cfg_data;
        CFG_SLICE: slice_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = !busy || (en && cnt == VTX_LAST);
  assign s_fire = s_tvalid && s_tready;
  assign in_range = ({1'b0, s_tdata[7:0]} < ns) && ({1'b0, s_tdata[15:8]} < nl);

  assign sel_up = (cnt == 3'd1) || (cnt == 3'd4) || (cnt == VTX_LAST);
  assign sel_hi = (cnt == 3'd2) || (cnt == 3'd3) || (cnt == VTX_LAST);
  assign vk = sel_up ? {1'b0, ci} : 9'({1'b0, ci} + 9'd1);
  assign vm = sel_hi ? 9'({1'b0, cj} + 9'd1) : {1'b0, cj};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= VTX_FIRST;
      jv <= 1'b0;
    end else begin
      if (en) begin
        jv <= busy;
        if (busy) begin
          cnt <= (cnt == VTX_LAST) ? VTX_FIRST : 3'(cnt + 3'd1);
          if (cnt == VTX_LAST) begin
            busy <= 1'b0;
          end
        end
      end
      if (s_fire) begin
        busy <= in_range;
        cnt <= VTX_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      ci <= s_tdata[7:0];
      cj <= s_tdata[15:8];
    end
    if (en) begin
      jk <= vk;
      jm <= vm;
      jpole <= (vk == 9'd0) || (vk == ns);
      jlast <= (cnt == VTX_LAST);
    end
  end

  uvs_div u_th_div (
    .clk(clk), .en(en),
    .dividend({jk, 20'd0} + 29'(ns)),
    .divisor({ns, 1'b0}),
    .quotient(th_quo)
  );

  uvs_div u_ph_div (
    .clk(clk), .en(en),
    .dividend({jm, 20'd0} + 29'(nl >> 1)),
    .divisor({1'b0, nl}),
    .quotient(ph_quo)
  );

  uvs_div u_u_div (
    .clk(clk), .en(en),
    .dividend(29'({jm, 14'd0}) + 29'(nl >> 1)),
    .divisor({1'b0, nl}),
    .quotient(u_quo)
  );

  uvs_div u_v_div (
    .clk(clk), .en(en),
    .dividend(29'({jk, 14'd0}) + 29'(ns >> 1)),
    .divisor({1'b0, ns}),
    .quotient(v_quo)
  );

  uvs_sincos u_th_sc (
    .clk(clk), .en(en), .phase(th_quo[19:0]), .sin_q30(ts), .cos_q30(tc)
  );

  uvs_sincos u_ph_sc (
    .clk(clk), .en(en), .phase(ph_quo[19:0]), .sin_q30(ps), .cos_q30(pc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < SIDE_LEN; n++) begin
        vp[n] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (en) begin
      vp[0] <= jv;
      for (int n = 1; n < SIDE_LEN; n++) begin
        vp[n] <= vp[n-1];
      end
      m_tvalid <= vp[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole_d[0] <= jpole;
      last_d[0] <= jlast;
      for (int n = 1; n < SIDE_LEN; n++) begin
        pole_d[n] <= pole_d[n-1];
        last_d[n] <= last_d[n-1];
      end
      u_d[0] <= u_quo[14:0];
      v_d[0] <= v_quo[14:0];
      for (int n = 1; n < TEX_LEN; n++) begin
        u_d[n] <= u_d[n-1];
        v_d[n] <= v_d[n-1];
      end
      pr_sc <= 63'(ts * pc);
      pr_ss <= 63'(ts * ps);
      pr_cc <= 63'(tc * pc);
      pr_cs <= 63'(tc * ps);
      tc_w <= 63'(tc);
      nts_w <= -63'(ts);
      pos_x <= rnd16(pr_sc, 47);
      pos_y <= rnd16(tc_w, 17);
      pos_z <= rnd16(pr_ss, 47);
      nrm_x <= rnd16(pr_sc, 46);
      nrm_y <= rnd16(tc_w, 16);
      nrm_z <= rnd16(pr_ss, 46);
      tan_x <= pole_d[SIDE_LEN-1] ? 16'd0 : rnd16(pr_cc, 46);
      tan_y <= pole_d[SIDE_LEN-1] ? 16'd0 : rnd16(nts_w, 16);
      tan_z <= pole_d[SIDE_LEN-1] ? 16'd0 : rnd16(pr_cs, 46);
      tex_u <= u_d[TEX_LEN-1];
      tex_v <= v_d[TEX_LEN-1];
      m_tlast <= last_d[SIDE_LEN-1];
    end
  end

  assign m_tdata = {2'b00, tex_v, tex_u, tan_z, tan_y, tan_x, nrm_z, nrm_y, nrm_x,
                    pos_z, pos_y, pos_x};

`ifndef SYNTH
  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    (busy && s_tready) |-> (cnt == VTX_LAST))
    else $error("cell taken while sequencer mid-cell");

  a_seq_done: assert property (@(posedge clk) disable iff (rst)
    (busy && en && cnt == VTX_LAST && !s_tvalid) |=> !busy)
    else $error("sequencer did not finish after sixth vertex");

  a_pole_tangent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && tex_v == 15'd0) |-> (tan_x == 16'd0 && tan_y == 16'd0 && tan_z == 16'd0))
    else $error("nonzero tangent at north pole");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !s_tvalid && en) |=> !jv)
    else $error("vertex issued with no cell held");
`endif

endmodule

/* sim/tb.sv */
module tb;

  localparam longint unsigned UNIT = 64'd1 << 30;
  localparam int LIMIT = 500000;

  typedef struct {
    logic [15:0] f[11];
    logic last;
  } vertex_t;

  typedef struct {
    bit is_cfg;
    logic [0:0] idx;
    logic [8:0] val;
    logic [7:0] stk;
    logic [7:0] slc;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [175:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  vertex_t vertex_q[$];
  int stack_reg = 16;
  int slice_reg = 16;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_cnt = 0;
  int cycles = 0;
  bit failed = 0;
  string fname[11] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z",
                       "tan_x", "tan_y", "tan_z", "tex_u", "tex_v"};

  uv_sphere_cell_vertex_generator i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic longint unsigned poly_sine(longint unsigned x);
    longint unsigned x2, s;
    x2 = (x * x) >> 30;
    s = UNIT - x2 / 42;
    s = UNIT - ((x2 * s) >> 30) / 20;
    s = UNIT - ((x2 * s) >> 30) / 6;
    return (x * s) >> 30;
  endfunction

  function automatic longint unsigned poly_cosine(longint unsigned x);
    longint unsigned x2, c;
    x2 = (x * x) >> 30;
    c = UNIT - x2 / 56;
    c = UNIT - ((x2 * c) >> 30) / 30;
    c = UNIT - ((x2 * c) >> 30) / 12;
    c = UNIT - ((x2 * c) >> 30) / 2;
    return c;
  endfunction

  task automatic turn_angle(input longint unsigned num, input longint unsigned den,
                            output longint sn, output longint cs);
    longint unsigned p, r, a, x;
    longint s0, c0;
    p = (((num << 20) + den / 2) / den) & 64'hFFFFF;
    r = p & 64'h3FFFF;
    a = (r <= 64'h20000) ? r : (64'h40000 - r);
    x = (a * 64'd1686629713 + (64'd1 << 17)) >> 18;
    if (r <= 64'h20000) begin
      s0 = poly_sine(x);
      c0 = poly_cosine(x);
    end else begin
      s0 = poly_cosine(x);
      c0 = poly_sine(x);
    end
    case (p >> 18)
      0: begin sn = s0; cs = c0; end
      1: begin sn = c0; cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endtask

  function automatic logic [15:0] round_q14(longint v, int sh);
    longint unsigned m, r;
    m = (v >= 0) ? v : -v;
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return (v >= 0) ? r[15:0] : 16'd0 - r[15:0];
  endfunction

  function automatic vertex_t make_vertex(longint ts, longint tc, longint ps, longint pc,
                                          bit pole, longint unsigned u, longint unsigned v,
                                          bit last);
    vertex_t o;
    o.f[0] = round_q14(ts * pc, 47);
    o.f[1] = round_q14(tc, 17);
    o.f[2] = round_q14(ts * ps, 47);
    o.f[3] = round_q14(ts * pc, 46);
    o.f[4] = round_q14(tc, 16);
    o.f[5] = round_q14(ts * ps, 46);
    o.f[6] = pole ? 16'd0 : round_q14(tc * pc, 46);
    o.f[7] = pole ? 16'd0 : round_q14(-ts, 16);
    o.f[8] = pole ? 16'd0 : round_q14(tc * ps, 46);
    o.f[9] = {1'b0, u[14:0]};
    o.f[10] = {1'b0, v[14:0]};
    o.last = last;
    return o;
  endfunction

  function automatic int eff_count(int r);
    return (r == 0) ? 1 : (r > 256 ? 256 : r);
  endfunction

  task automatic predict_cell(int i, int j);
    int ns, nl;
    longint us, uc, ds, dc, ls, lc, hs, hc;
    longint unsigned u_lo, u_hi, v_up, v_dn;
    bit p_up, p_dn;
    ns = eff_count(stack_reg);
    nl = eff_count(slice_reg);
    if (i >= ns || j >= nl) return;
    turn_angle(i, 2 * ns, us, uc);
    turn_angle(i + 1, 2 * ns, ds, dc);
    turn_angle(j, nl, ls, lc);
    turn_angle(j + 1, nl, hs, hc);
    u_lo = (longint'(j) * 16384 + nl / 2) / nl;
    u_hi = (longint'(j + 1) * 16384 + nl / 2) / nl;
    v_up = (longint'(i) * 16384 + ns / 2) / ns;
    v_dn = (longint'(i + 1) * 16384 + ns / 2) / ns;
    p_up = (i == 0);
    p_dn = (i + 1 == ns);
    vertex_q.push_back(make_vertex(ds, dc, ls, lc, p_dn, u_lo, v_dn, 0));
    vertex_q.push_back(make_vertex(us, uc, ls, lc, p_up, u_lo, v_up, 0));
    vertex_q.push_back(make_vertex(ds, dc, hs, hc, p_dn, u_hi, v_dn, 0));
    vertex_q.push_back(make_vertex(ds, dc, hs, hc, p_dn, u_hi, v_dn, 0));
    vertex_q.push_back(make_vertex(us, uc, ls, lc, p_up, u_lo, v_up, 0));
    vertex_q.push_back(make_vertex(us, uc, hs, hc, p_up, u_hi, v_up, 1));
  endtask

  // called and returns at a falling edge
  task automatic send_cell(logic [7:0] i, logic [7:0] j);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {j, i};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cell(i, j);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == uvs_pkg::CFG_STACK) stack_reg = val;
    else slice_reg = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    vertex_t exp_v;
    logic [15:0] got;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, m_tdata);
        failed = 1;
      end else begin
        exp_v = vertex_q.pop_front();
        for (int k = 0; k < 11; k++) begin
          got = (k < 9) ? m_tdata[16*k +: 16] : {1'b0, m_tdata[144 + 15*(k-9) +: 15]};
          if (got !== exp_v.f[k]) begin
            $display("%0t: %s expected %h got %h", $time, fname[k], exp_v.f[k], got);
            failed = 1;
          end
        end
        if (m_tlast !== exp_v.last) begin
          $display("%0t: last expected %b got %b", $time, exp_v.last, m_tlast);
          failed = 1;
        end
      end
    end
  end

  row_t plan[$] = '{
    '{0, 0, 0, 0, 0}, '{0, 0, 0, 15, 15}, '{0, 0, 0, 16, 0}, '{0, 0, 0, 0, 16},
    '{0, 0, 0, 255, 255}, '{0, 0, 0, 7, 3},
    '{1, uvs_pkg::CFG_STACK, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 1, 0},
    '{1, uvs_pkg::CFG_STACK, 256, 0, 0}, '{1, uvs_pkg::CFG_SLICE, 256, 0, 0},
    '{0, 0, 0, 255, 255}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 128, 64}, '{0, 0, 0, 170, 85},
    '{1, uvs_pkg::CFG_STACK, 511, 0, 0}, '{1, uvs_pkg::CFG_SLICE, 0, 0, 0},
    '{0, 0, 0, 200, 0}, '{0, 0, 0, 3, 1}, '{0, 0, 0, 255, 0},
    '{1, uvs_pkg::CFG_STACK, 2, 0, 0}, '{1, uvs_pkg::CFG_SLICE, 3, 0, 0},
    '{0, 0, 0, 1, 2}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 2, 0}
  };

  int counts[11] = '{0, 1, 2, 3, 7, 16, 100, 255, 256, 300, 511};

  initial begin
    int ns, nl;
    logic [7:0] i, j;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    tx_idle = 0;
    rx_idle = 30;
    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        drain();
        write_reg(plan[n].idx, plan[n].val);
      end else begin
        send_cell(plan[n].stk, plan[n].slc);
      end
    end
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      if (ph == 1) begin
        write_reg(uvs_pkg::CFG_STACK, 9'd256);
        write_reg(uvs_pkg::CFG_SLICE, 9'd256);
      end else begin
        write_reg(uvs_pkg::CFG_STACK, 9'(counts[$urandom_range(10)]));
        write_reg(uvs_pkg::CFG_SLICE, 9'(counts[$urandom_range(10)]));
      end
      tx_idle = (ph == 0) ? 19 : (ph == 1 ? 81 : 0);
      rx_idle = (ph == 0) ? 81 : (ph == 1 ? 19 : 0);
      if (ph == 0) hold_cnt = 300;
      ns = eff_count(stack_reg);
      nl = eff_count(slice_reg);
      for (int n = 0; n < 133; n++) begin
        if ($urandom_range(99) < 85) begin
          i = 8'($urandom_range(ns - 1));
          j = 8'($urandom_range(nl - 1));
        end else begin
          i = 8'($urandom);
          j = 8'($urandom);
        end
        send_cell(i, j);
      end
    end
    drain();
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/uvs_pkg.sv
rtl/uvs_div.sv
rtl/uvs_sincos.sv
rtl/uv_sphere_cell_vertex_generator.sv
sim/tb.sv
